// File: rtl/core/fpa_pkg.sv
// fpa_pkg: shared codes for the fit placement allocator.
// Request types, status codes, fit modes and controller states.
// No dependencies.
package fpa_pkg;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_ALLOC   = 2'd1;
    localparam logic [1:0] REQ_RESTORE = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;
    localparam logic [1:0] MODE_NEXT  = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_COPY   = 8'b0000_0010,
        S_CHOOSE = 8'b0000_0100,
        S_SHIFT  = 8'b0000_1000,
        S_WRC    = 8'b0001_0000,
        S_WRN    = 8'b0010_0000,
        S_STATS  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

endpackage

// File: rtl/core/fpa_ram.sv
// fpa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/fit_placement_allocator.sv
// fit_placement_allocator: top level, request sequencer around two entry RAMs.
// Depends on fpa_pkg and fpa_ram.
//
// Keeps an ordered table of memory blocks (size, used flag, owner) in one RAM and
// the loaded layout in a second RAM. One request is worked at a time; each pass
// over the table reads one entry per cycle from the entry RAM's single read port,
// so the cost follows the table size N (current count) and L (loaded count).
// A read runs only the statistics pass; restore and an accepted load first copy
// the layout (N equals L once the copy is done), and an allocate on a non-empty
// table runs a choose pass, a shift pass when it splits, and the statistics pass.
// After loading the output register the block goes back to idle before taking the
// next request. The next request is taken while a result still waits on the output
// register. fit_mode is to be written through i_cfg_we / i_cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module fit_placement_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int OWNER_BITS = 8,
    localparam int IDX_W   = $clog2(MAX_BLOCKS),
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1),
    localparam int TOT_W   = SIZE_BITS + IDX_W,
    localparam int IN_RAW  = SIZE_BITS + OWNER_BITS + IDX_W,
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = IDX_W + SIZE_BITS + 1 + OWNER_BITS + 1 + TOT_W
                             + SIZE_BITS + 2 * CNT_W,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_wdata,     // fit_mode
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // req_size, req_owner, entry_sel
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    input  logic [1:0]       i_s_axis_tuser,  // req_type
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // entry_index, entry_size, entry_used, entry_owner, split_made,
    // total_free, largest_free, free_count, block_count
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser   // status
);
    import fpa_pkg::*;

    localparam int ENT_W = SIZE_BITS + 1 + OWNER_BITS;

    t_state r_state;
    logic [1:0]            r_mode, r_status;
    logic [SIZE_BITS-1:0]  r_size, r_psize, r_esize, r_lrg;
    logic [OWNER_BITS-1:0] r_owner, r_eown;
    logic [IDX_W-1:0]      r_rover, r_scan, r_pidx, r_pick, r_idx;
    logic [CNT_W-1:0]      r_cur_count, r_ld_count, r_ptr, r_nfree;
    logic [TOT_W-1:0]      r_tot;
    logic                  r_pv, r_found, r_split, r_show, r_eused;
    logic                  r_ovalid;
    logic [OUT_W-1:0]      r_otdata;
    logic [1:0]            r_otuser;

    logic                  cur_we, ld_we;
    logic [IDX_W-1:0]      cur_waddr, cur_raddr, ld_raddr;
    logic [ENT_W-1:0]      cur_wdata, cur_rdata;
    logic [SIZE_BITS-1:0]  ld_rdata;

    logic [SIZE_BITS-1:0]  rd_size;
    logic                  rd_used;
    logic [OWNER_BITS-1:0] rd_owner;
    logic                  s_accept, fits, better;
    logic [CNT_W-1:0]      scan_inc, pick_inc, ptr_dec, new_count;
    logic [SIZE_BITS-1:0]  in_size;
    logic [OWNER_BITS-1:0] in_owner;
    logic [IDX_W-1:0]      in_sel;
    logic [OUT_W-1:0]      out_word;

    assign in_size  = i_s_axis_tdata[SIZE_BITS-1:0];
    assign in_owner = i_s_axis_tdata[SIZE_BITS +: OWNER_BITS];
    assign in_sel   = i_s_axis_tdata[SIZE_BITS + OWNER_BITS +: IDX_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign rd_size  = cur_rdata[SIZE_BITS-1:0];
    assign rd_used  = cur_rdata[SIZE_BITS];
    assign rd_owner = cur_rdata[SIZE_BITS+1 +: OWNER_BITS];

    assign fits   = !rd_used && (rd_size >= r_size);
    assign better = ((r_mode == MODE_BEST) && (rd_size < r_psize)) ||
                    ((r_mode == MODE_WORST) && (rd_size > r_psize));

    assign scan_inc  = {1'b0, r_scan} + CNT_W'(1);
    assign pick_inc  = {1'b0, r_pick} + CNT_W'(1);
    assign ptr_dec   = r_ptr - CNT_W'(1);
    assign new_count = r_cur_count + CNT_W'(r_split);

    fpa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    fpa_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_ld_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (r_ld_count[IDX_W-1:0]),
        .i_wdata (in_size),
        .i_raddr (ld_raddr),
        .o_rdata (ld_rdata)
    );

    // RAM port control
    always_comb begin
        ld_we     = s_accept && (i_s_axis_tuser == REQ_LOAD) &&
                    (r_ld_count < CNT_W'(MAX_BLOCKS));
        ld_raddr  = r_ptr[IDX_W-1:0];
        cur_we    = 1'b0;
        cur_waddr = r_pidx;
        cur_wdata = {{OWNER_BITS{1'b0}}, 1'b0, ld_rdata};
        cur_raddr = r_ptr[IDX_W-1:0];
        unique case (r_state)
            S_COPY: begin
                cur_we = r_pv;
            end
            S_CHOOSE: begin
                cur_raddr = r_scan;
            end
            S_SHIFT: begin
                cur_raddr = ptr_dec[IDX_W-1:0];
                cur_we    = r_pv;
                cur_waddr = r_pidx + IDX_W'(1);
                cur_wdata = cur_rdata;
            end
            S_WRC: begin
                cur_we    = 1'b1;
                cur_waddr = r_pick;
                cur_wdata = {r_owner, 1'b1, r_split ? r_size : r_psize};
            end
            S_WRN: begin
                cur_we    = 1'b1;
                cur_waddr = pick_inc[IDX_W-1:0];
                cur_wdata = {{OWNER_BITS{1'b0}}, 1'b0, r_psize - r_size};
            end
            S_IDLE, S_STATS, S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_word = '0;
        out_word[OUT_RAW-1:0] = {r_cur_count, r_nfree, r_lrg, r_tot, r_split,
                                 r_eown, r_eused, r_esize, r_idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_FIRST;
            r_cur_count <= '0;
            r_ld_count  <= '0;
            r_rover     <= '0;
            r_ptr       <= '0;
            r_pv        <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            // S_OUT reloads the output register itself
            if (r_ovalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_size   <= in_size;
                        r_owner  <= in_owner;
                        r_split  <= 1'b0;
                        r_found  <= 1'b0;
                        r_tot    <= '0;
                        r_lrg    <= '0;
                        r_nfree  <= '0;
                        r_esize  <= '0;
                        r_eused  <= 1'b0;
                        r_eown   <= '0;
                        r_ptr    <= '0;
                        r_pv     <= 1'b0;
                        case (i_s_axis_tuser)
                            REQ_LOAD: begin
                                if (r_ld_count >= CNT_W'(MAX_BLOCKS)) begin
                                    r_status <= ST_FULL;
                                    r_idx    <= '0;
                                    r_show   <= 1'b0;
                                    r_state  <= S_STATS;
                                end else begin
                                    r_status   <= ST_DONE;
                                    r_idx      <= r_ld_count[IDX_W-1:0];
                                    r_show     <= 1'b1;
                                    r_ld_count <= r_ld_count + CNT_W'(1);
                                    r_state    <= S_COPY;
                                end
                            end
                            REQ_ALLOC: begin
                                r_idx  <= '0;
                                r_show <= 1'b0;
                                if (r_cur_count == '0) begin
                                    r_status <= ST_NOFIT;
                                    r_state  <= S_STATS;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_scan  <= ((r_mode == MODE_NEXT) &&
                                                ({1'b0, r_rover} < r_cur_count))
                                               ? r_rover : '0;
                                    r_state <= S_CHOOSE;
                                end
                            end
                            REQ_RESTORE: begin
                                r_status <= ST_DONE;
                                r_idx    <= '0;
                                r_show   <= 1'b0;
                                r_state  <= S_COPY;
                            end
                            default: begin
                                r_idx <= in_sel;
                                if ({1'b0, in_sel} < r_cur_count) begin
                                    r_show   <= 1'b1;
                                    r_status <= ST_DONE;
                                end else begin
                                    r_show   <= 1'b0;
                                    r_status <= ST_BADIDX;
                                end
                                r_state <= S_STATS;
                            end
                        endcase
                    end
                end
                S_COPY: begin
                    if (r_ptr < r_ld_count) begin
                        r_pidx <= r_ptr[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                        r_pv   <= 1'b1;
                    end else if (r_pv) begin
                        r_pv <= 1'b0;
                    end else begin
                        r_cur_count <= r_ld_count;
                        r_rover     <= '0;
                        r_ptr       <= '0;
                        r_state     <= S_STATS;
                    end
                end
                S_CHOOSE: begin
                    if (r_ptr < r_cur_count) begin
                        r_pidx <= r_scan;
                        r_scan <= (scan_inc >= r_cur_count) ? '0 : scan_inc[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && fits && (!r_found || better)) begin
                        r_found <= 1'b1;
                        r_pick  <= r_pidx;
                        r_psize <= rd_size;
                    end
                    if (!(r_ptr < r_cur_count) && !r_pv) begin
                        if (!r_found) begin
                            r_status <= ST_NOFIT;
                            r_ptr    <= '0;
                            r_state  <= S_STATS;
                        end else begin
                            r_idx  <= r_pick;
                            r_show <= 1'b1;
                            if ((r_psize > r_size) &&
                                (r_cur_count < CNT_W'(MAX_BLOCKS))) begin
                                r_split <= 1'b1;
                                r_ptr   <= r_cur_count;
                                r_state <= S_SHIFT;
                            end else begin
                                r_state <= S_WRC;
                            end
                        end
                    end
                end
                S_SHIFT: begin
                    // move entries pick+1 .. count-1 up by one, top first
                    if (r_ptr > pick_inc) begin
                        r_pidx <= ptr_dec[IDX_W-1:0];
                        r_ptr  <= ptr_dec;
                        r_pv   <= 1'b1;
                    end else if (r_pv) begin
                        r_pv <= 1'b0;
                    end else begin
                        r_state <= S_WRC;
                    end
                end
                S_WRC, S_WRN: begin
                    if ((r_state == S_WRC) && r_split) begin
                        r_state <= S_WRN;
                    end else begin
                        r_cur_count <= new_count;
                        if (r_mode == MODE_NEXT) begin
                            r_rover <= (pick_inc < new_count) ? pick_inc[IDX_W-1:0] : '0;
                        end
                        r_ptr   <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_STATS;
                    end
                end
                S_STATS: begin
                    if (r_ptr < r_cur_count) begin
                        r_pidx <= r_ptr[IDX_W-1:0];
                        r_ptr  <= r_ptr + CNT_W'(1);
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (!rd_used) begin
                            r_tot   <= r_tot + TOT_W'(rd_size);
                            r_nfree <= r_nfree + CNT_W'(1);
                            if (rd_size > r_lrg) begin
                                r_lrg <= rd_size;
                            end
                        end
                        if (r_show && (r_pidx == r_idx)) begin
                            r_esize <= rd_size;
                            r_eused <= rd_used;
                            r_eown  <= rd_used ? rd_owner : '0;
                        end
                    end
                    if (!(r_ptr < r_cur_count) && !r_pv) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_otdata <= out_word;
                        r_otuser <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_otdata;
    assign o_m_axis_tuser  = r_otuser;

endmodule

// File: test/testbench.sv
// testbench: self-checking bench for fit_placement_allocator.
// Drives request transactions, predicts each result with a scoreboard model of the
// block table, and compares every output field. Depends on fpa_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import fpa_pkg::*;

    localparam int IN_W  = 32;
    localparam int OUT_W = 80;
    localparam int NBLK  = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] size;
        logic        used;
        logic [7:0]  owner;
        logic        split;
        logic [19:0] total;
        logic [15:0] largest;
        logic [4:0]  nfree;
        logic [4:0]  count;
        logic [1:0]  status;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [1:0]  mode;
        logic [15:0] sizes[NBLK];
        logic        used[NBLK];
        logic [7:0]  owners[NBLK];
        logic [15:0] layout[NBLK];
        int          layout_n;
        int          count;
        int          rover;
        t_alloc_result pending[$];
        int          errors;

        function new();
            mode = MODE_FIRST;
            layout_n = 0;
            errors = 0;
            restore_table();
        endfunction

        function void restore_table();
            for (int i = 0; i < NBLK; i++) begin
                sizes[i] = (i < layout_n) ? layout[i] : 16'd0;
                used[i] = 1'b0;
                owners[i] = 8'd0;
            end
            count = layout_n;
            rover = 0;
        endfunction

        function bit fits(int i, logic [15:0] need);
            return !used[i] && sizes[i] >= need;
        endfunction

        function int pick_block(logic [15:0] need);
            int pick;
            int start;
            int j;
            pick = count;
            case (mode)
                MODE_FIRST: begin
                    for (int i = 0; i < count; i++)
                        if (fits(i, need)) return i;
                end
                MODE_BEST, MODE_WORST: begin
                    for (int i = 0; i < count; i++) begin
                        if (!fits(i, need)) continue;
                        if (pick == count) pick = i;
                        else if (mode == MODE_BEST ? sizes[i] < sizes[pick]
                                                   : sizes[i] > sizes[pick]) pick = i;
                    end
                end
                default: begin
                    start = (rover < count) ? rover : 0;
                    for (int k = 0; k < count; k++) begin
                        j = start + k;
                        if (j >= count) j -= count;
                        if (fits(j, need)) return j;
                    end
                end
            endcase
            return pick;
        endfunction

        function void note_request(logic [1:0] kind, logic [15:0] req_size,
                                   logic [7:0] owner, logic [3:0] sel);
            t_alloc_result r;
            bit show;
            int c;
            r = '0;
            show = 0;
            case (kind)
                REQ_LOAD: begin
                    if (layout_n >= NBLK) r.status = ST_FULL;
                    else begin
                        layout[layout_n] = req_size;
                        layout_n++;
                        restore_table();
                        r.index = 4'(layout_n - 1);
                        show = 1;
                    end
                end
                REQ_ALLOC: begin
                    c = pick_block(req_size);
                    if (c >= count) r.status = ST_NOFIT;
                    else begin
                        used[c] = 1'b1;
                        owners[c] = owner;
                        if (sizes[c] > req_size && count < NBLK) begin
                            for (int i = count; i > c + 1; i--) begin
                                sizes[i] = sizes[i-1];
                                used[i] = used[i-1];
                                owners[i] = owners[i-1];
                            end
                            sizes[c+1] = sizes[c] - req_size;
                            used[c+1] = 1'b0;
                            owners[c+1] = 8'd0;
                            sizes[c] = req_size;
                            count++;
                            r.split = 1'b1;
                        end
                        if (mode == MODE_NEXT) rover = (c + 1 < count) ? c + 1 : 0;
                        r.index = 4'(c);
                        show = 1;
                    end
                end
                REQ_RESTORE: restore_table();
                default: begin
                    r.index = sel;
                    if (sel < count) show = 1;
                    else r.status = ST_BADIDX;
                end
            endcase
            if (show) begin
                r.size = sizes[r.index];
                r.used = used[r.index];
                r.owner = used[r.index] ? owners[r.index] : 8'd0;
            end
            for (int i = 0; i < count; i++) begin
                if (!used[i]) begin
                    r.total = r.total + 20'(sizes[i]);
                    r.nfree++;
                    if (sizes[i] > r.largest) r.largest = sizes[i];
                end
            end
            r.count = 5'(count);
            pending = {pending, r};
        endfunction

        function void report(string field, longint exp, longint act);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
            errors++;
        endfunction

        function void check_result(t_alloc_result got);
            t_alloc_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status != exp.status) report("status", exp.status, got.status);
            if (got.index != exp.index) report("entry_index", exp.index, got.index);
            if (got.size != exp.size) report("entry_size", exp.size, got.size);
            if (got.used != exp.used) report("entry_used", exp.used, got.used);
            if (got.owner != exp.owner) report("entry_owner", exp.owner, got.owner);
            if (got.split != exp.split) report("split_made", exp.split, got.split);
            if (got.total != exp.total) report("total_free", exp.total, got.total);
            if (got.largest != exp.largest) report("largest_free", exp.largest, got.largest);
            if (got.nfree != exp.nfree) report("free_count", exp.nfree, got.nfree);
            if (got.count != exp.count) report("block_count", exp.count, got.count);
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_wdata = '0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata = '0;
    logic [1:0]       i_s_axis_tuser = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic [1:0]       o_m_axis_tuser;

    alloc_scoreboard table_sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 0;
    longint cycles = 0;

    fit_placement_allocator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: sample, then choose tready for the next cycle
    always @(posedge i_clk) begin
        t_alloc_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.index   = o_m_axis_tdata[3:0];
            got.size    = o_m_axis_tdata[19:4];
            got.used    = o_m_axis_tdata[20];
            got.owner   = o_m_axis_tdata[28:21];
            got.split   = o_m_axis_tdata[29];
            got.total   = o_m_axis_tdata[49:30];
            got.largest = o_m_axis_tdata[65:50];
            got.nfree   = o_m_axis_tdata[70:66];
            got.count   = o_m_axis_tdata[75:71];
            got.status  = o_m_axis_tuser;
            table_sb.check_result(got);
        end
        i_m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // the block stays busy after an accept, so the idle wait at the end of this task
    // costs no throughput
    task automatic send_request(logic [1:0] kind, logic [15:0] req_size,
                                logic [7:0] owner, logic [3:0] sel);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {4'b0, sel, owner, req_size};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        table_sb.note_request(kind, req_size, owner, sel);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_sb.mode = m;
    endtask

    // random size: mostly small so allocations fit, sometimes extreme
    function automatic logic [15:0] rand_size();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return $urandom_range(2) == 0 ? 16'hFFFF : 16'd0;
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                // append to the layout; once it is full these report table full
                send_request(REQ_LOAD, 16'($urandom_range(50, 2000)), 8'd0, 4'd0);
            end else if (r < 65)
                send_request(REQ_ALLOC, rand_size(), 8'($urandom_range(1, 255)),
                             4'($urandom));
            else if (r < 75)
                send_request(REQ_RESTORE, 16'($urandom), 8'($urandom), 4'($urandom));
            else
                send_request(REQ_READ, 16'($urandom), 8'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        table_sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table cases, loads with extremes, full table
        send_request(REQ_ALLOC, 16'd1, 8'd1, 4'd0);
        send_request(REQ_READ, 16'd0, 8'd0, 4'd0);
        send_request(REQ_RESTORE, 16'd0, 8'd0, 4'd0);
        send_request(REQ_LOAD, 16'hFFFF, 8'hFF, 4'hF);
        send_request(REQ_LOAD, 16'd0, 8'd0, 4'd0);
        send_request(REQ_ALLOC, 16'd0, 8'hFF, 4'd0);
        send_request(REQ_ALLOC, 16'h8000, 8'd1, 4'd0);
        send_request(REQ_READ, 16'd0, 8'd0, 4'hF);
        send_request(REQ_READ, 16'd0, 8'd0, 4'd1);
        for (int i = 0; i < 15; i++) send_request(REQ_LOAD, 16'(100 + i), 8'd0, 4'd0);
        set_mode(MODE_NEXT);
        send_request(REQ_ALLOC, 16'd50, 8'h55, 4'd0);
        send_request(REQ_ALLOC, 16'd200, 8'hAA, 4'd0);

        // pressure: receiver holds off while requests keep coming
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge i_clk);
                recv_hold = 0;
            end
            for (int i = 0; i < 12; i++) send_request(REQ_READ, 16'd0, 8'd0, 4'($urandom));
        join

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 31 : phase == 1 ? 49 : 0;
            recv_idle_pct = phase == 0 ? 49 : phase == 1 ? 31 : 0;
            for (int m = 0; m < 4; m++) begin
                set_mode(m[1:0]);
                random_phase(135);
            end
        end
        drain();
        if (table_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
